### hdl/signed_restoring_divider_unit_defines.svh
// Assertion macros shared by the checker file of the signed restoring divider.
`ifndef SIGNED_RESTORING_DIVIDER_UNIT_DEFINES_SVH
`define SIGNED_RESTORING_DIVIDER_UNIT_DEFINES_SVH

// Property checked at each rising clock edge outside reset.
`define SDRU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("signed restoring divider: assertion failed");

// Property checked at each rising clock edge, reset included.
`define SDRU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("signed restoring divider: assertion failed");

`endif

### hdl/sdru_pkg.sv
`timescale 1ns / 1ps

package sdru_pkg;

    // Operand and quotient width.
    localparam int SDRU_WIDTH = 32;

    typedef struct packed {
        logic signed [SDRU_WIDTH-1:0] dividend;
        logic signed [SDRU_WIDTH-1:0] divisor;
    } t_sdru_in;

    typedef struct packed {
        logic signed [SDRU_WIDTH-1:0] quotient;
        logic                         div_by_zero;
    } t_sdru_out;

    // Working state of one item as it travels along the cell chain.
    typedef struct packed {
        logic [SDRU_WIDTH-1:0] rem;
        logic [SDRU_WIDTH-1:0] den;
        logic [SDRU_WIDTH-1:0] quo;
        logic                  neg;
        logic                  dbz;
    } t_sdru_stage;

endpackage

### hdl/sdru_cell.sv
`timescale 1ns / 1ps

// One restoring step: decides quotient bit BIT and registers the result.
module sdru_cell import sdru_pkg::*; #(
    parameter int BIT = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_sdru_stage i_stage,
    output logic        o_valid,
    output t_sdru_stage o_stage
);

    logic        r_valid;
    t_sdru_stage r_stage;
    t_sdru_stage n_stage;

    // The shifted remainder test avoids widening the divisor by BIT bits.
    always_comb begin
        n_stage = i_stage;
        if ((i_stage.rem >> BIT) >= i_stage.den) begin
            n_stage.quo[BIT] = 1'b1;
            n_stage.rem      = i_stage.rem - (i_stage.den << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### hdl/signed_restoring_divider_unit.sv
`timescale 1ns / 1ps

// Channel   Valid     Ready     Payload   Direction
// input     i_valid   o_ready   i_data    dividend and divisor in
// output    o_valid   i_ready   o_data    quotient and zero-divisor flag out
//
// An accepted item is loaded into the operand stage, then passes through one cell per
// quotient bit and last through the output register before its result is shown.
// A new item is accepted each cycle the chain advances; the SDRU_WIDTH cells set the latency.
// Reset (i_rst_n low at a clock edge) empties the chain; payload registers keep their values.
// When a result waits at the output and i_ready is low, the whole chain holds still.
module signed_restoring_divider_unit import sdru_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_sdru_in  i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_sdru_out o_data,
    input  logic      i_ready
);

    // Single advance signal for every stage: the chain moves whenever the
    // output register is empty or its item is being taken this cycle.
    logic advance;

    // Stage 0 is the operand register; stage k+1 is the output of cell k.
    logic        valid_chain [0:SDRU_WIDTH];
    t_sdru_stage stage_chain [0:SDRU_WIDTH];

    logic        r_prep_valid;
    t_sdru_stage r_prep;
    t_sdru_stage n_prep;

    logic        r_out_valid;
    t_sdru_out   r_out;
    t_sdru_out   n_out;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = advance;

    // Operand stage: take magnitudes of both operands and note the sign of
    // the result. The most negative value maps onto its own bit pattern,
    // which read as unsigned is exactly its magnitude.
    always_comb begin
        n_prep.rem = i_data.dividend[SDRU_WIDTH-1] ? (-i_data.dividend) : i_data.dividend;
        n_prep.den = i_data.divisor[SDRU_WIDTH-1]  ? (-i_data.divisor)  : i_data.divisor;
        n_prep.quo = '0;
        n_prep.neg = i_data.dividend[SDRU_WIDTH-1] ^ i_data.divisor[SDRU_WIDTH-1];
        n_prep.dbz = (i_data.divisor == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (advance) begin
            r_prep_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_prep <= n_prep;
        end
    end

    assign valid_chain[0] = r_prep_valid;
    assign stage_chain[0] = r_prep;

    // One cell per quotient bit, most significant bit first.
    for (genvar k = 0; k < SDRU_WIDTH; k++) begin : g_cell
        sdru_cell #(
            .BIT (SDRU_WIDTH - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (valid_chain[k]),
            .i_stage (stage_chain[k]),
            .o_valid (valid_chain[k+1]),
            .o_stage (stage_chain[k+1])
        );
    end

    // Output stage: apply the sign, and force a zero quotient when the
    // divisor was zero (the cells run on regardless in that case).
    always_comb begin
        n_out.div_by_zero = stage_chain[SDRU_WIDTH].dbz;
        if (stage_chain[SDRU_WIDTH].dbz) begin
            n_out.quotient = '0;
        end else if (stage_chain[SDRU_WIDTH].neg) begin
            n_out.quotient = -stage_chain[SDRU_WIDTH].quo;
        end else begin
            n_out.quotient = stage_chain[SDRU_WIDTH].quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= valid_chain[SDRU_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### hdl/sdru_checker.sv
`timescale 1ns / 1ps
`include "signed_restoring_divider_unit_defines.svh"

// Port-level checks on the signed restoring divider.
module sdru_checker import sdru_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input t_sdru_in  i_data,
    input logic      o_ready,
    input logic      o_valid,
    input t_sdru_out o_data,
    input logic      i_ready
);

    // The output is empty in the cycle after a reset edge.
    `SDRU_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_valid)

    // A result that is not taken stays, unchanged.
    `SDRU_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_data))

    // An offered item that is not taken stays, unchanged.
    `SDRU_ASSERT(a_in_hold, i_valid && !o_ready |=> i_valid && $stable(i_data))

    // A zero divisor always yields a zero quotient.
    `SDRU_ASSERT(a_dbz_zero, o_valid && o_data.div_by_zero |-> o_data.quotient == '0)

    // The input side accepts exactly when the output side can move.
    `SDRU_ASSERT(a_ready_link, o_ready == (!o_valid || i_ready))

endmodule

bind signed_restoring_divider_unit sdru_checker u_sdru_checker (.*);
